/* design/pdve_pkg.sv */
// ----------------------------------------------------------------------------
// pdve_pkg
// Shared types and constants of the position-derived velocity estimator.
// ----------------------------------------------------------------------------
package pdve_pkg;

    localparam int POS_W   = 16;
    localparam int TIME_W  = 32;
    localparam int VEL_W   = 16;
    localparam int FILT_W  = 24;
    localparam int IDX_W   = 3;
    localparam int CDATA_W = 17;

    localparam int WIN_W   = 10;
    localparam int TMO_W   = 14;
    localparam int ALPHA_W = 17;
    localparam int DB_W    = 10;
    localparam int REJ_W   = 15;

    // Dividend is |dpos| * 256000, which needs 34 bits.
    localparam int DIV_N_W = 34;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [IDX_W-1:0] REG_WINDOW   = 3'd0;
    localparam logic [IDX_W-1:0] REG_TIMEOUT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ALPHA    = 3'd2;
    localparam logic [IDX_W-1:0] REG_DEADBAND = 3'd3;
    localparam logic [IDX_W-1:0] REG_REJECT   = 3'd4;

    localparam logic [WIN_W-1:0]   WINDOW_RST   = 10'd200;
    localparam logic [TMO_W-1:0]   TIMEOUT_RST  = 14'd300;
    localparam logic [ALPHA_W-1:0] ALPHA_RST    = 17'd39322;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 17'd65536;
    localparam logic [DB_W-1:0]    DEADBAND_RST = 10'd3;
    localparam logic [REJ_W-1:0]   REJECT_RST   = 15'd150;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
        logic               rem_nz;
    } t_div_res;

endpackage

/* design/pdve_if.sv */
// ----------------------------------------------------------------------------
// pdve channel interfaces
// Sample input, velocity output and configuration write channels.
// ----------------------------------------------------------------------------
interface pdve_in_if;
    import pdve_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x_cm;
    logic signed [POS_W-1:0]  pos_y_cm;
    logic        [TIME_W-1:0] time_ms;
    modport source (output valid, pos_x_cm, pos_y_cm, time_ms, input ready);
    modport sink   (input valid, pos_x_cm, pos_y_cm, time_ms, output ready);
endinterface

interface pdve_out_if;
    import pdve_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] vel_x_cmps;
    logic signed [VEL_W-1:0] vel_y_cmps;
    modport source (output valid, vel_x_cmps, vel_y_cmps, input ready);
    modport sink   (input valid, vel_x_cmps, vel_y_cmps, output ready);
endinterface

interface pdve_cfg_if;
    import pdve_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   index;
    logic [CDATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/pdve_div.sv */
// ----------------------------------------------------------------------------
// pdve_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdve_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pdve_pkg::DIV_N_W-1:0] i_dividend,
    input  logic [pdve_pkg::TIME_W-1:0]  i_divisor,
    output pdve_pkg::t_div_res        o_res
);
    import pdve_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_quot;
    logic [TIME_W-1:0]    r_rem;
    logic [TIME_W-1:0]    r_div;
    logic [TIME_W:0]      w_rem_sh;
    logic [TIME_W:0]      w_sub;
    logic                 w_ge;

    assign w_rem_sh = {r_rem, r_quot[DIV_N_W-1]};
    assign w_sub    = w_rem_sh - {1'b0, r_div};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_N_W-2:0], w_ge};
            r_rem  <= w_ge ? w_sub[TIME_W-1:0] : w_rem_sh[TIME_W-1:0];
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quot   = r_quot;
    assign o_res.rem_nz = r_rem != '0;

endmodule

/* design/position_derived_velocity_estimator.sv */
// ----------------------------------------------------------------------------
// position_derived_velocity_estimator
// Filtered X/Y velocity from timestamped X/Y position samples.
//
//   Port    Dir   Beat contents
//   i_in    in    pos_x_cm, pos_y_cm, time_ms
//   o_out   out   vel_x_cmps, vel_y_cmps
//   i_cfg   in    index, data (register write)
//
// A sample that anchors, is the second sample, or falls inside the window
// goes from S_CHECK straight to S_OUT. A differentiated sample waits in S_DIV
// for the 34-step bit-serial divider, then S_REJ, and S_MUL/S_UPD if kept.
// Reset is synchronous; there is no clearing pass. A waiting output beat does
// not block the next input beat, which stalls only at its own result.
// ----------------------------------------------------------------------------
module position_derived_velocity_estimator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdve_in_if.sink    i_in,
    pdve_out_if.source o_out,
    pdve_cfg_if.sink   i_cfg
);
    import pdve_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_REJ   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    function automatic logic [VEL_W-1:0] publish(input logic signed [FILT_W-1:0] f,
                                                 input logic [DB_W-1:0] db);
        logic [FILT_W-1:0] mag;
        logic [FILT_W:0]   rnd;
        logic [VEL_W-1:0]  r;
        mag = f[FILT_W-1] ? FILT_W'(-f) : FILT_W'(f);
        rnd = {1'b0, mag} + (FILT_W+1)'(128);
        r   = rnd[VEL_W+7:8];
        if (mag < {6'b0, db, 8'b0}) begin
            publish = '0;
        end else begin
            publish = f[FILT_W-1] ? VEL_W'(-r) : r;
        end
    endfunction

    logic [2:0]               r_state;
    logic                     r_started;
    logic                     r_have_two;
    logic signed [POS_W-1:0]  r_old_x;
    logic signed [POS_W-1:0]  r_old_y;
    logic [TIME_W-1:0]        r_old_time;
    logic signed [POS_W-1:0]  r_new_x;
    logic signed [POS_W-1:0]  r_new_y;
    logic [TIME_W-1:0]        r_new_time;
    logic signed [FILT_W-1:0] r_filt_x;
    logic signed [FILT_W-1:0] r_filt_y;

    logic [WIN_W-1:0]         r_window_ms;
    logic [TMO_W-1:0]         r_timeout_ms;
    logic [ALPHA_W-1:0]       r_alpha_q16;
    logic [DB_W-1:0]          r_deadband_cmps;
    logic [REJ_W-1:0]         r_reject_cmps;

    logic signed [POS_W-1:0]  r_in_x;
    logic signed [POS_W-1:0]  r_in_y;
    logic [TIME_W-1:0]        r_in_t;
    logic                     r_neg_x;
    logic                     r_neg_y;
    logic signed [FILT_W-1:0] r_rx;
    logic signed [FILT_W-1:0] r_ry;
    logic signed [42:0]       r_prod_x;
    logic signed [42:0]       r_prod_y;

    logic                     r_out_valid;
    logic [VEL_W-1:0]         r_out_x;
    logic [VEL_W-1:0]         r_out_y;

    logic [TIME_W-1:0]        w_latest;
    logic [TIME_W-1:0]        w_gap;
    logic [TIME_W-1:0]        w_elapsed;
    logic                     w_anchor;
    logic                     w_go;
    logic signed [POS_W:0]    w_dpos_x;
    logic signed [POS_W:0]    w_dpos_y;
    logic [POS_W:0]           w_mag_x;
    logic [POS_W:0]           w_mag_y;
    logic [22:0]              w_m125_x;
    logic [22:0]              w_m125_y;
    logic                     w_div_start;
    t_div_res                 w_res_x;
    t_div_res                 w_res_y;
    logic [DIV_N_W:0]         w_abs_x;
    logic [DIV_N_W:0]         w_abs_y;
    logic [DIV_N_W:0]         w_lim;
    logic                     w_keep;
    logic [ALPHA_W-1:0]       w_alpha;
    logic signed [FILT_W:0]   w_diff_x;
    logic signed [FILT_W:0]   w_diff_y;
    logic                     w_out_free;

    assign w_latest  = r_have_two ? r_new_time : r_old_time;
    assign w_gap     = r_in_t - w_latest;
    assign w_elapsed = r_in_t - r_old_time;
    assign w_anchor  = !r_started || (w_gap > {18'b0, r_timeout_ms});
    assign w_go      = (w_elapsed != '0) && (w_elapsed >= {22'b0, r_window_ms});

    assign w_dpos_x = {r_in_x[POS_W-1], r_in_x} - {r_old_x[POS_W-1], r_old_x};
    assign w_dpos_y = {r_in_y[POS_W-1], r_in_y} - {r_old_y[POS_W-1], r_old_y};
    assign w_mag_x  = w_dpos_x[POS_W] ? (POS_W+1)'(-w_dpos_x) : w_dpos_x;
    assign w_mag_y  = w_dpos_y[POS_W] ? (POS_W+1)'(-w_dpos_y) : w_dpos_y;
    assign w_m125_x = {7'b0, w_mag_x[POS_W-1:0]} * 23'd125;
    assign w_m125_y = {7'b0, w_mag_y[POS_W-1:0]} * 23'd125;

    assign w_div_start = (r_state == S_CHECK) && !w_anchor && r_have_two && w_go;

    pdve_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_m125_x, 11'b0}),
        .i_divisor  (w_elapsed),
        .o_res      (w_res_x)
    );

    pdve_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_m125_y, 11'b0}),
        .i_divisor  (w_elapsed),
        .o_res      (w_res_y)
    );

    // Floor division rounds a negative quotient with a remainder one further out.
    assign w_abs_x = {1'b0, w_res_x.quot} + (DIV_N_W+1)'(r_neg_x && w_res_x.rem_nz);
    assign w_abs_y = {1'b0, w_res_y.quot} + (DIV_N_W+1)'(r_neg_y && w_res_y.rem_nz);
    assign w_lim   = {12'b0, r_reject_cmps, 8'b0};
    assign w_keep  = (w_abs_x <= w_lim) && (w_abs_y <= w_lim);

    assign w_alpha  = (r_alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : r_alpha_q16;
    assign w_diff_x = {r_rx[FILT_W-1], r_rx} - {r_filt_x[FILT_W-1], r_filt_x};
    assign w_diff_y = {r_ry[FILT_W-1], r_ry} - {r_filt_y[FILT_W-1], r_filt_y};

    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms     <= WINDOW_RST;
            r_timeout_ms    <= TIMEOUT_RST;
            r_alpha_q16     <= ALPHA_RST;
            r_deadband_cmps <= DEADBAND_RST;
            r_reject_cmps   <= REJECT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_WINDOW:   r_window_ms     <= i_cfg.data[WIN_W-1:0];
                REG_TIMEOUT:  r_timeout_ms    <= i_cfg.data[TMO_W-1:0];
                REG_ALPHA:    r_alpha_q16     <= i_cfg.data[ALPHA_W-1:0];
                REG_DEADBAND: r_deadband_cmps <= i_cfg.data[DB_W-1:0];
                REG_REJECT:   r_reject_cmps   <= i_cfg.data[REJ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_have_two  <= 1'b0;
            r_old_x     <= '0;
            r_old_y     <= '0;
            r_old_time  <= '0;
            r_new_x     <= '0;
            r_new_y     <= '0;
            r_new_time  <= '0;
            r_filt_x    <= '0;
            r_filt_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_neg_x <= w_dpos_x[POS_W];
                    r_neg_y <= w_dpos_y[POS_W];
                    if (w_anchor) begin
                        r_started  <= 1'b1;
                        r_have_two <= 1'b0;
                        r_old_x    <= r_in_x;
                        r_old_y    <= r_in_y;
                        r_old_time <= r_in_t;
                        r_new_x    <= r_in_x;
                        r_new_y    <= r_in_y;
                        r_new_time <= r_in_t;
                        r_filt_x   <= '0;
                        r_filt_y   <= '0;
                        r_state    <= S_OUT;
                    end else if (!r_have_two || !w_go) begin
                        r_have_two <= 1'b1;
                        r_new_x    <= r_in_x;
                        r_new_y    <= r_in_y;
                        r_new_time <= r_in_t;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_res_x.done) begin
                        r_state <= S_REJ;
                    end
                end
                S_REJ: begin
                    r_old_x    <= r_new_x;
                    r_old_y    <= r_new_y;
                    r_old_time <= r_new_time;
                    r_new_x    <= r_in_x;
                    r_new_y    <= r_in_y;
                    r_new_time <= r_in_t;
                    r_rx <= r_neg_x ? FILT_W'(-w_abs_x) : w_abs_x[FILT_W-1:0];
                    r_ry <= r_neg_y ? FILT_W'(-w_abs_y) : w_abs_y[FILT_W-1:0];
                    r_state <= w_keep ? S_MUL : S_OUT;
                end
                S_MUL: begin
                    r_prod_x <= w_diff_x * $signed({1'b0, w_alpha});
                    r_prod_y <= w_diff_y * $signed({1'b0, w_alpha});
                    r_state  <= S_UPD;
                end
                S_UPD: begin
                    r_filt_x <= r_filt_x + r_prod_x[FILT_W+15:16];
                    r_filt_y <= r_filt_y + r_prod_y[FILT_W+15:16];
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_in_x <= i_in.pos_x_cm;
            r_in_y <= i_in.pos_y_cm;
            r_in_t <= i_in.time_ms;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_x <= publish(r_filt_x, r_deadband_cmps);
            r_out_y <= publish(r_filt_y, r_deadband_cmps);
        end
    end

    assign i_in.ready       = r_state == S_IDLE;
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.vel_x_cmps = r_out_x;
    assign o_out.vel_y_cmps = r_out_y;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while a sample is still in work");

    a_two_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_two |-> r_started)
        else $error("second sample held without an anchor");

    a_beat_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state) == S_OUT)
        else $error("output beat raised outside the output step");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_x.done |-> (r_state == S_DIV && w_res_y.done))
        else $error("divider finished outside the divide step");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the position-derived velocity estimator. Directed
// and random-walk position samples go through several register settings while
// both channels idle at random. Every velocity beat is compared, field by
// field, with an in-bench model of the estimator.
// ----------------------------------------------------------------------------
module tb;
    import pdve_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;
    localparam int WALK_ITEMS  = 85;
    localparam int WALK_PHASES = 10;
    localparam int UNIT_Q16    = 65536;

    localparam logic [IDX_W-1:0] REG_NONE_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_NONE_HI = 3'd7;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic        [TIME_W-1:0] t;
    } t_sample;

    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
    } t_vel;

    logic i_clk;
    logic i_rst_n;

    pdve_in_if  in_if ();
    pdve_out_if out_if ();
    pdve_cfg_if cfg_if ();

    position_derived_velocity_estimator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_sample sample_queue[$];
    t_vel    vel_expect[$];

    int in_gap;
    int out_stall;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    int errors;
    int samples_sent;
    int beats_checked;
    int reg_writes;
    int settings_used;

    int m_win;
    int m_tmo;
    int m_alpha;
    int m_db;
    int m_rej;
    bit m_started;
    bit m_have_two;
    logic signed [POS_W-1:0]  m_old_x;
    logic signed [POS_W-1:0]  m_old_y;
    logic        [TIME_W-1:0] m_old_t;
    logic signed [POS_W-1:0]  m_new_x;
    logic signed [POS_W-1:0]  m_new_y;
    logic        [TIME_W-1:0] m_new_t;
    longint m_filt_x;
    longint m_filt_y;

    int gen_win;
    int gen_tmo;
    int gen_rej;
    bit gen_junk;
    logic signed [POS_W-1:0]  walk_x;
    logic signed [POS_W-1:0]  walk_y;
    logic        [TIME_W-1:0] walk_t;
    int walk_vx;
    int walk_vy;

    t_sample drv_sample;
    t_vel    mon_expect;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic logic signed [VEL_W-1:0] round_speed(longint f);
        longint mag;
        longint r;
        mag = (f < 0) ? -f : f;
        if (mag < longint'(m_db) * 256) return '0;
        r = (mag + 128) >>> 8;
        if (f < 0) r = -r;
        return r[VEL_W-1:0];
    endfunction

    function automatic void reanchor(t_sample s);
        m_started  = 1'b1;
        m_have_two = 1'b0;
        m_old_x = s.x;
        m_old_y = s.y;
        m_old_t = s.t;
        m_new_x = s.x;
        m_new_y = s.y;
        m_new_t = s.t;
        m_filt_x = 0;
        m_filt_y = 0;
    endfunction

    function automatic void model_reset();
        m_win   = WINDOW_RST;
        m_tmo   = TIMEOUT_RST;
        m_alpha = ALPHA_RST;
        m_db    = DEADBAND_RST;
        m_rej   = REJECT_RST;
        m_started  = 1'b0;
        m_have_two = 1'b0;
        m_old_x = '0;
        m_old_y = '0;
        m_old_t = '0;
        m_new_x = '0;
        m_new_y = '0;
        m_new_t = '0;
        m_filt_x = 0;
        m_filt_y = 0;
    endfunction

    function automatic void model_write(logic [IDX_W-1:0] idx, logic [CDATA_W-1:0] val);
        case (idx)
            REG_WINDOW:   m_win   = val[WIN_W-1:0];
            REG_TIMEOUT:  m_tmo   = val[TMO_W-1:0];
            REG_ALPHA:    m_alpha = val[ALPHA_W-1:0];
            REG_DEADBAND: m_db    = val[DB_W-1:0];
            REG_REJECT:   m_rej   = val[REJ_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_vel predict_velocity(t_sample s);
        logic [TIME_W-1:0] latest;
        logic [TIME_W-1:0] since;
        logic [TIME_W-1:0] elapsed;
        longint rx;
        longint ry;
        longint lim;
        longint gain;
        t_vel   v;
        if (!m_started) begin
            reanchor(s);
        end else begin
            latest = m_have_two ? m_new_t : m_old_t;
            since  = s.t - latest;
            if (longint'(since) > longint'(m_tmo)) begin
                reanchor(s);
            end else if (!m_have_two) begin
                m_new_x = s.x;
                m_new_y = s.y;
                m_new_t = s.t;
                m_have_two = 1'b1;
            end else begin
                elapsed = s.t - m_old_t;
                if (elapsed != '0 && longint'(elapsed) >= longint'(m_win)) begin
                    rx = floor_quot((longint'(s.x) - longint'(m_old_x)) * 256000,
                                    longint'(elapsed));
                    ry = floor_quot((longint'(s.y) - longint'(m_old_y)) * 256000,
                                    longint'(elapsed));
                    lim = longint'(m_rej) * 256;
                    if ((rx < 0 ? -rx : rx) <= lim && (ry < 0 ? -ry : ry) <= lim) begin
                        gain = (m_alpha > UNIT_Q16) ? UNIT_Q16 : m_alpha;
                        m_filt_x = m_filt_x + floor_quot(gain * (rx - m_filt_x), UNIT_Q16);
                        m_filt_y = m_filt_y + floor_quot(gain * (ry - m_filt_y), UNIT_Q16);
                    end
                    m_old_x = m_new_x;
                    m_old_y = m_new_y;
                    m_old_t = m_new_t;
                end
                m_new_x = s.x;
                m_new_y = s.y;
                m_new_t = s.t;
            end
        end
        v.vx = round_speed(m_filt_x);
        v.vy = round_speed(m_filt_y);
        return v;
    endfunction

    // Input driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_gap <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_gap != 0) begin
                in_gap <= in_gap - 1;
                in_if.valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                drv_sample = sample_queue.pop_front();
                in_if.valid    <= 1'b1;
                in_if.pos_x_cm <= drv_sample.x;
                in_if.pos_y_cm <= drv_sample.y;
                in_if.time_ms  <= drv_sample.t;
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                    in_gap <= $urandom_range(1, 10);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Output back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_stall <= 0;
        end else if (out_stall != 0) begin
            out_stall <= out_stall - 1;
            out_if.ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            out_stall <= $urandom_range(0, 9);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Monitor and scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) model_write(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready) begin
                drv_sample.x = in_if.pos_x_cm;
                drv_sample.y = in_if.pos_y_cm;
                drv_sample.t = in_if.time_ms;
                vel_expect.push_back(predict_velocity(drv_sample));
            end
            if (out_if.valid && out_if.ready) begin
                beats_checked++;
                if (vel_expect.size() == 0) begin
                    $error("Velocity beat with no sample pending: x=%0d y=%0d",
                           out_if.vel_x_cmps, out_if.vel_y_cmps);
                    errors++;
                end else begin
                    mon_expect = vel_expect.pop_front();
                    if (out_if.vel_x_cmps !== mon_expect.vx) begin
                        $error("vel_x_cmps expected %0d actual %0d",
                               mon_expect.vx, out_if.vel_x_cmps);
                        errors++;
                    end
                    if (out_if.vel_y_cmps !== mon_expect.vy) begin
                        $error("vel_y_cmps expected %0d actual %0d",
                               mon_expect.vy, out_if.vel_y_cmps);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        reg_writes++;
    endtask

    function automatic logic [CDATA_W-1:0] with_junk(int val, int w);
        logic [CDATA_W-1:0] d;
        d = CDATA_W'(val);
        if (gen_junk && w < CDATA_W) d = d | CDATA_W'($urandom << w);
        return d;
    endfunction

    task automatic apply_settings(input int win, input int tmo, input int alpha,
                                  input int db, input int rej);
        write_reg(REG_WINDOW,   with_junk(win, WIN_W));
        write_reg(REG_TIMEOUT,  with_junk(tmo, TMO_W));
        write_reg(REG_ALPHA,    CDATA_W'(alpha));
        write_reg(REG_DEADBAND, with_junk(db, DB_W));
        write_reg(REG_REJECT,   with_junk(rej, REJ_W));
        gen_win = win;
        gen_tmo = tmo;
        gen_rej = rej;
        settings_used++;
    endtask

    task automatic add_sample(input int x, input int y, input logic [TIME_W-1:0] t);
        t_sample s;
        s.x = POS_W'(x);
        s.y = POS_W'(y);
        s.t = t;
        sample_queue.push_back(s);
        samples_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (sample_queue.size() != 0 || in_if.valid || vel_expect.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic queue_walk(input int count);
        int r;
        int dt;
        int dx;
        int dy;
        int lo;
        int hi;
        int span;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                walk_x = POS_W'($urandom);
                walk_y = POS_W'($urandom);
                walk_t = $urandom;
            end else begin
                r = $urandom_range(0, 99);
                hi = (gen_tmo < gen_win + 20) ? gen_tmo : gen_win + 20;
                lo = (gen_win / 2 < hi) ? gen_win / 2 : hi;
                if (r < 8) dt = 0;
                else if (r < 16) dt = gen_tmo + $urandom_range(1, 400);
                else if (r < 30) dt = $urandom_range(0, gen_tmo);
                else dt = $urandom_range(lo, hi);
                if ($urandom_range(0, 19) == 0) begin
                    span = gen_rej + gen_rej / 4 + 2;
                    walk_vx = int'($urandom_range(0, 2 * span)) - span;
                    walk_vy = int'($urandom_range(0, 2 * span)) - span;
                end
                dx = walk_vx * dt / 1000 + int'($urandom_range(0, 2)) - 1;
                dy = walk_vy * dt / 1000 + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 99) < 3) dx = dx + int'($urandom_range(0, 4000)) - 2000;
                walk_x = POS_W'(walk_x + dx);
                walk_y = POS_W'(walk_y + dy);
                walk_t = walk_t + TIME_W'(dt);
            end
            add_sample(walk_x, walk_y, walk_t);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.pos_x_cm = '0;
        in_if.pos_y_cm = '0;
        in_if.time_ms = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        in_gap = 0;
        out_stall = 0;
        quiet_cycles = 0;
        errors = 0;
        samples_sent = 0;
        beats_checked = 0;
        reg_writes = 0;
        settings_used = 1;
        idle_pct = 20;
        stall_pct = 20;
        gen_win = WINDOW_RST;
        gen_tmo = TIMEOUT_RST;
        gen_rej = REJECT_RST;
        gen_junk = 1'b0;
        walk_x = '0;
        walk_y = '0;
        walk_t = '0;
        walk_vx = 0;
        walk_vy = 0;
        model_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: first sample, second sample, reject limit, timeout,
        // extreme positions and timestamp wrap.
        @(negedge i_clk);
        add_sample(0, 0, 1000);
        add_sample(10, 0, 1100);
        add_sample(20, 5, 1200);
        add_sample(40, 10, 1300);
        add_sample(41, 10, 1350);
        add_sample(80, 10, 1400);
        add_sample(20, 0, 1650);
        add_sample(20, 0, 1951);
        add_sample(20, 0, 2251);
        add_sample(32767, -32768, 9000);
        add_sample(-32768, 32767, 9100);
        add_sample(32767, -32768, 9300);
        add_sample(-32768, 32767, 9500);
        add_sample(0, 0, 32'hFFFF_FFFF);
        add_sample(1, -1, 32'h0000_0063);
        add_sample(2, -2, 32'h0000_00C7);
        add_sample(-1, 1, 32'h0000_0000);
        wait_drained();

        // Zero window: equal timestamps must never be differentiated.
        apply_settings(0, 300, 39322, 0, 1000);
        @(negedge i_clk);
        add_sample(5, 5, 50000);
        add_sample(5, 5, 50000);
        add_sample(6, 4, 50000);
        add_sample(6, 4, 50001);
        add_sample(5, 5, 50002);
        add_sample(4, 6, 50004);
        wait_drained();

        for (int p = 0; p < WALK_PHASES; p++) begin
            gen_junk = ($urandom_range(0, 1) == 1);
            case (p)
                0: apply_settings(1, 16383, UNIT_Q16, 0, 32767);
                1: begin
                    apply_settings(1023, 1, 0, 1023, 0);
                    write_reg(REG_NONE_LO, CDATA_W'($urandom));
                    write_reg(REG_NONE_HI, CDATA_W'($urandom));
                end
                2: apply_settings(0, 5000, 131071, 1, 500);
                3: apply_settings($urandom_range(0, 1023), $urandom_range(0, 16383),
                                  $urandom_range(0, 131071), $urandom_range(0, 1023),
                                  $urandom_range(0, 32767));
                default: begin
                    gen_win = $urandom_range(0, 400);
                    apply_settings(gen_win, gen_win * 2 + $urandom_range(1, 3000),
                                   $urandom_range(0, 70000), $urandom_range(0, 10),
                                   $urandom_range(10, 3000));
                end
            endcase
            case (p % 3)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 15;
                    stall_pct = 15;
                end
                default: begin
                    idle_pct = 40;
                    stall_pct = 40;
                end
            endcase
            if (p == WALK_PHASES - 1) begin
                idle_pct = 0;
                stall_pct = 0;
            end
            walk_t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535)
                                                 : $urandom;
            @(negedge i_clk);
            queue_walk(WALK_ITEMS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (vel_expect.size() != 0) begin
            $error("%0d velocity beats never arrived", vel_expect.size());
            errors++;
        end
        $display("Sent %0d position samples and checked %0d velocity beats.",
                 samples_sent, beats_checked);
        $display("Used %0d register settings with %0d register writes.",
                 settings_used, reg_writes);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
